// File: rtl/s2pc_pkg.sv
// ----------------------------------------------------------------------------
// Scalar to pseudo color: shared definitions
// Widths, fixed-point constants, register indexes and types used by the
// colormap pipeline and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package s2pc_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned JET_ENTRIES = 1024;

  localparam int unsigned NORM_W = FRAC_BITS + 1;
  localparam logic [NORM_W-1:0] ONE_FX = NORM_W'(1) << FRAC_BITS;

  localparam logic [DATA_W-1:0] RANGE_ONE = DATA_W'(32'h0001_0000);

  localparam int unsigned K066 = (66 * (2 ** FRAC_BITS) + 50) / 100;

  localparam int unsigned JET_L   = JET_ENTRIES - 1;
  localparam int unsigned IDX_W   = $clog2(JET_ENTRIES);
  localparam int unsigned MUL_B_W = (IDX_W > FRAC_BITS) ? IDX_W : FRAC_BITS;
  localparam int unsigned SCL_W   = MUL_B_W;

  localparam int unsigned T_W       = IDX_W + CHAN_W;
  localparam int unsigned LOG_L     = $clog2(JET_L);
  localparam int unsigned RECIP_S   = T_W + LOG_L;
  localparam int unsigned RECIP_M_W = T_W + 1;
  localparam logic [RECIP_M_W-1:0] RECIP_M =
    RECIP_M_W'(((64'd1 << RECIP_S) + 64'(JET_L) - 64'd1) / 64'(JET_L));

  localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

  localparam int unsigned PIPE_DEPTH = 2 + FRAC_BITS + 3;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE  = 2'd0,
    CFG_LOW   = 2'd1,
    CFG_RANGE = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    MODE_JET = 1'b0,
    MODE_HSV = 1'b1
  } cmap_mode_e;

  typedef struct packed {
    logic zero;
    logic one;
  } clamp_t;

endpackage

// File: rtl/s2pc_div.sv
// ----------------------------------------------------------------------------
// Scalar to pseudo color: normalizing divider
// Restoring division pipeline that forms one quotient bit per stage and then
// applies the clamp decided ahead of it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module s2pc_div import s2pc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DATA_W-1:0] rem_i,
  input  clamp_t            clamp_i,
  input  logic [DATA_W-1:0] span_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [NORM_W-1:0] norm_o
);

  localparam int unsigned STEPS = FRAC_BITS;

  logic                 vld_q   [STEPS];
  logic [DATA_W-1:0]    rem_q   [STEPS];
  logic [FRAC_BITS-1:0] quo_q   [STEPS];
  clamp_t               clamp_q [STEPS];
  logic [STEPS:0]       rdy;

  assign rdy[STEPS] = out_ready_i;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic                 vld_in;
    logic [DATA_W-1:0]    rem_in;
    logic [FRAC_BITS-1:0] quo_in;
    clamp_t               clamp_in;
    logic [DATA_W:0]      shl;
    logic [DATA_W:0]      sub;
    logic                 take;

    if (k == 0) begin : g_first
      assign vld_in   = in_valid_i;
      assign rem_in   = rem_i;
      assign quo_in   = '0;
      assign clamp_in = clamp_i;
    end else begin : g_next
      assign vld_in   = vld_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign quo_in   = quo_q[k-1];
      assign clamp_in = clamp_q[k-1];
    end

    assign rdy[k] = !vld_q[k] || rdy[k+1];
    assign shl    = {rem_in, 1'b0};
    assign sub    = shl - {1'b0, span_i};
    assign take   = shl >= {1'b0, span_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && vld_in) begin
        rem_q[k]   <= take ? sub[DATA_W-1:0] : shl[DATA_W-1:0];
        quo_q[k]   <= {quo_in[FRAC_BITS-2:0], take};
        clamp_q[k] <= clamp_in;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[STEPS-1];

  always_comb begin
    if (clamp_q[STEPS-1].zero) begin
      norm_o = '0;
    end else if (clamp_q[STEPS-1].one) begin
      norm_o = ONE_FX;
    end else begin
      norm_o = {1'b0, quo_q[STEPS-1]};
    end
  end

endmodule

// File: rtl/s2pc_cmap.sv
// ----------------------------------------------------------------------------
// Scalar to pseudo color: colormap stages
// Three register stages that turn a normalized value into a jet ramp color
// or a blue to red hue ramp color.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module s2pc_cmap import s2pc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [NORM_W-1:0] norm_i,
  input  cmap_mode_e        mode_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CHAN_W-1:0] red_o,
  output logic [CHAN_W-1:0] green_o,
  output logic [CHAN_W-1:0] blue_o
);

  localparam int unsigned I4_W = IDX_W + 2;
  localparam logic [I4_W-1:0] L1 = I4_W'(JET_L);
  localparam logic [I4_W-1:0] L2 = I4_W'(2 * JET_L);
  localparam logic [I4_W-1:0] L3 = I4_W'(3 * JET_L);
  localparam logic [I4_W-1:0] L4 = I4_W'(4 * JET_L);

  typedef enum logic [1:0] {
    SEG_RISE_G,
    SEG_FALL_B,
    SEG_RISE_R,
    SEG_FALL_G
  } jet_seg_e;

  typedef enum logic [2:0] {
    SEC_R_RISE_G,
    SEC_G_FALL_R,
    SEC_G_RISE_B,
    SEC_B_FALL_G,
    SEC_B_RISE_R,
    SEC_R_FALL_B
  } hue_sec_e;

  function automatic logic [CHAN_W-1:0] chan_scale(input logic [NORM_W-1:0] c);
    logic [NORM_W+CHAN_W-1:0] p;
    p = {c, CHAN_W'(0)} - (NORM_W + CHAN_W)'(c);
    return p[FRAC_BITS +: CHAN_W];
  endfunction

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Stage 1: one shared multiplier scales norm to the ramp index or the hue.
  logic [NORM_W-1:0]         mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic [NORM_W+MUL_B_W-1:0] prod1;
  logic [SCL_W-1:0]          scl_q;

  always_comb begin
    if (mode_i == MODE_HSV) begin
      mul_a = ONE_FX - norm_i;
      mul_b = MUL_B_W'(K066);
    end else begin
      mul_a = norm_i;
      mul_b = MUL_B_W'(JET_L);
    end
    prod1 = (NORM_W + MUL_B_W)'(mul_a) * (NORM_W + MUL_B_W)'(mul_b);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      scl_q <= prod1[FRAC_BITS +: SCL_W];
    end
  end

  // Stage 2: jet segment decode, and the complete hue to RGB conversion.
  logic [IDX_W-1:0]       idx;
  logic [I4_W-1:0]        i4;
  jet_seg_e               seg_d;
  logic [IDX_W-1:0]       k_d;
  logic [FRAC_BITS-1:0]   hue;
  logic [FRAC_BITS+2:0]   h6;
  logic [2:0]             sector;
  logic [NORM_W-1:0]      x;
  logic [NORM_W-1:0]      rc, gc, bc;
  jet_seg_e               seg_q;
  logic [T_W-1:0]         t_q;
  logic [CHAN_W-1:0]      hr_q, hg_q, hb_q;

  always_comb begin
    idx = scl_q[IDX_W-1:0];
    i4  = {idx, 2'b00};
    if (i4 < L1) begin
      seg_d = SEG_RISE_G;
      k_d   = IDX_W'(i4);
    end else if (i4 < L2) begin
      seg_d = SEG_FALL_B;
      k_d   = IDX_W'(L2 - i4);
    end else if (i4 < L3) begin
      seg_d = SEG_RISE_R;
      k_d   = IDX_W'(i4 - L2);
    end else begin
      seg_d = SEG_FALL_G;
      k_d   = IDX_W'(L4 - i4);
    end
  end

  always_comb begin
    hue    = scl_q[FRAC_BITS-1:0];
    h6     = (FRAC_BITS + 3)'({hue, 2'b00}) + (FRAC_BITS + 3)'({hue, 1'b0});
    sector = h6[FRAC_BITS +: 3];
    x      = sector[0] ? (ONE_FX - NORM_W'(h6[FRAC_BITS-1:0]))
                       : NORM_W'(h6[FRAC_BITS-1:0]);
    rc = '0;
    gc = '0;
    bc = '0;
    case (hue_sec_e'(sector))
      SEC_R_RISE_G: begin
        rc = ONE_FX;
        gc = x;
      end
      SEC_G_FALL_R: begin
        rc = x;
        gc = ONE_FX;
      end
      SEC_G_RISE_B: begin
        gc = ONE_FX;
        bc = x;
      end
      SEC_B_FALL_G: begin
        gc = x;
        bc = ONE_FX;
      end
      SEC_B_RISE_R: begin
        rc = x;
        bc = ONE_FX;
      end
      default: begin
        rc = ONE_FX;
        bc = x;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      seg_q <= seg_d;
      t_q   <= T_W'({k_d, CHAN_W'(0)}) - T_W'(k_d);
      hr_q  <= chan_scale(rc);
      hg_q  <= chan_scale(gc);
      hb_q  <= chan_scale(bc);
    end
  end

  // Stage 3: floor(255 * k / L) by reciprocal multiplication, then assembly.
  logic [T_W+RECIP_M_W-1:0] prod3;
  logic [CHAN_W-1:0]        ch;
  logic [CHAN_W-1:0]        r_d, g_d, b_d;
  logic [CHAN_W-1:0]        r_q, g_q, b_q;

  always_comb begin
    prod3 = (T_W + RECIP_M_W)'(t_q) * (T_W + RECIP_M_W)'(RECIP_M);
    ch    = prod3[RECIP_S +: CHAN_W];
    if (mode_i == MODE_HSV) begin
      r_d = hr_q;
      g_d = hg_q;
      b_d = hb_q;
    end else begin
      case (seg_q)
        SEG_RISE_G: begin
          r_d = '0;
          g_d = ch;
          b_d = CHAN_MAX;
        end
        SEG_FALL_B: begin
          r_d = '0;
          g_d = CHAN_MAX;
          b_d = ch;
        end
        SEG_RISE_R: begin
          r_d = ch;
          g_d = CHAN_MAX;
          b_d = '0;
        end
        default: begin
          r_d = CHAN_MAX;
          g_d = ch;
          b_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      r_q <= r_d;
      g_q <= g_d;
      b_q <= b_d;
    end
  end

  assign out_valid_o = v3_q;
  assign red_o       = r_q;
  assign green_o     = g_q;
  assign blue_o      = b_q;

endmodule

// File: rtl/scalar_to_pseudo_color.sv
// ----------------------------------------------------------------------------
// Scalar to pseudo color
// Maps a signed Q16.16 sample onto an 8-bit RGB color through a jet ramp or
// a blue to red hue ramp, normalized against a programmable span.
// Stages: each sample passes through two front stages, one divider stage
// per fraction bit (16) and three colormap stages before its color is
// valid on the output.
// Throughput is one item per cycle unless the output stalls; every stage has
// its own valid bit, so a stalled output only holds the stages that are full.
// Reset clears all valid bits and loads mode 0, low 0 and range 1.0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scalar_to_pseudo_color import s2pc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CHAN_W-1:0]    red_o,
  output logic [CHAN_W-1:0]    green_o,
  output logic [CHAN_W-1:0]    blue_o
);

  cmap_mode_e               mode_q;
  logic signed [DATA_W-1:0] low_q;
  logic [DATA_W-1:0]        range_q;
  logic [DATA_W-1:0]        span;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_JET;
      low_q   <= '0;
      range_q <= RANGE_ONE;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_MODE:  mode_q  <= cmap_mode_e'(cfg_wdata_i[0]);
        CFG_LOW:   low_q   <= cfg_wdata_i;
        CFG_RANGE: range_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign span = (range_q == '0) ? RANGE_ONE : range_q;

  logic              a_vld_q, b_vld_q;
  logic              rdy_a, rdy_b;
  logic              div_in_ready;
  logic [DATA_W:0]   diff_d, diff_q;
  clamp_t            clamp_d, b_clamp_q;
  logic [DATA_W-1:0] b_rem_q;

  assign rdy_b      = !b_vld_q || div_in_ready;
  assign rdy_a      = !a_vld_q || rdy_b;
  assign in_ready_o = rdy_a;

  assign diff_d = {value_i[DATA_W-1], value_i} - {low_q[DATA_W-1], low_q};

  always_comb begin
    clamp_d.zero = diff_q[DATA_W] || (diff_q == '0);
    clamp_d.one  = !clamp_d.zero && (diff_q[DATA_W-1:0] >= span);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        a_vld_q <= in_valid_i;
      end
      if (rdy_b) begin
        b_vld_q <= a_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      diff_q <= diff_d;
    end
    if (rdy_b && a_vld_q) begin
      b_rem_q   <= diff_q[DATA_W-1:0];
      b_clamp_q <= clamp_d;
    end
  end

  logic              div_out_valid;
  logic              cmap_in_ready;
  logic [NORM_W-1:0] norm;

  s2pc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (b_vld_q),
    .in_ready_o  (div_in_ready),
    .rem_i       (b_rem_q),
    .clamp_i     (b_clamp_q),
    .span_i      (span),
    .out_valid_o (div_out_valid),
    .out_ready_i (cmap_in_ready),
    .norm_o      (norm)
  );

  s2pc_cmap u_cmap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_out_valid),
    .in_ready_o  (cmap_in_ready),
    .norm_i      (norm),
    .mode_i      (mode_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

endmodule

// File: rtl/s2pc_checker.sv
// ----------------------------------------------------------------------------
// Scalar to pseudo color: port checker
// Watches the ports of the top level: item accounting, reset behavior,
// output hold under stall and the shape of every produced color.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module s2pc_checker import s2pc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [CHAN_W-1:0] red_o,
  input logic [CHAN_W-1:0] green_o,
  input logic [CHAN_W-1:0] blue_o
);

  localparam int unsigned CNT_W = $clog2(PIPE_DEPTH + 1) + 1;

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] cnt_d, cnt_q;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign cnt_d   = cnt_q + CNT_W'(in_acc) - CNT_W'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(red_o) && $stable(green_o) && $stable(blue_o))
    else $error("stalled output item changed or was dropped");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != '0)
    else $error("output item without a matching input item");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

  a_color_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (red_o == CHAN_MAX || green_o == CHAN_MAX || blue_o == CHAN_MAX) &&
      (red_o == '0 || green_o == '0 || blue_o == '0))
    else $error("color lacks a saturated or an empty channel");

endmodule

bind scalar_to_pseudo_color s2pc_checker u_s2pc_checker (.*);

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Scalar to pseudo color: self-checking testbench
// Streams signed Q16.16 samples through the colormap block under many span
// and ramp settings, with random gaps on the input and random back-pressure
// on the output. Every output color is compared against an in-line integer
// model of the jet and hue ramps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top import s2pc_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 110;
  localparam longint FX_ONE = longint'(1) << FRAC_BITS;
  localparam longint FX_MASK = FX_ONE - 1;
  localparam longint JET_STEPS = longint'(JET_ENTRIES) - 1;
  localparam longint HUE_TOP = (66 * FX_ONE + 50) / 100;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } color_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_W-1:0]     cfg_idx_i;
  logic [DATA_W-1:0]        cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [DATA_W-1:0] value_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [CHAN_W-1:0]        red_o;
  logic [CHAN_W-1:0]        green_o;
  logic [CHAN_W-1:0]        blue_o;

  cmap_mode_e               ramp_mode;
  logic signed [DATA_W-1:0] span_low;
  logic [DATA_W-1:0]        span_width;

  color_t      pending_colors[$];
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned colors_checked = 0;
  int unsigned settings_used = 0;
  bit          src_steady = 1'b0;
  bit          sink_steady = 1'b0;

  scalar_to_pseudo_color dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d colors outstanding.",
               cycle_count, pending_colors.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic longint to_channel(input longint comp);
    return ((comp * 255) >> FRAC_BITS) & 255;
  endfunction

  function automatic color_t map_color(input logic signed [DATA_W-1:0] sample);
    longint diff;
    longint span;
    longint norm;
    longint idx;
    longint i4;
    longint hue;
    longint h6;
    longint sector;
    longint frac;
    longint x;
    longint rc;
    longint gc;
    longint bc;
    color_t c;
    diff = longint'(sample) - longint'(span_low);
    span = (span_width == '0) ? FX_ONE : longint'({32'b0, span_width});
    if (diff <= 0) begin
      norm = 0;
    end else if (diff >= span) begin
      norm = FX_ONE;
    end else begin
      norm = (diff << FRAC_BITS) / span;
    end
    if (ramp_mode == MODE_JET) begin
      idx = (norm * JET_STEPS) >> FRAC_BITS;
      i4 = 4 * idx;
      if (i4 < JET_STEPS) begin
        rc = 0;
        gc = (1020 * idx) / JET_STEPS;
        bc = 255;
      end else if (i4 < 2 * JET_STEPS) begin
        rc = 0;
        gc = 255;
        bc = (255 * (2 * JET_STEPS - i4)) / JET_STEPS;
      end else if (i4 < 3 * JET_STEPS) begin
        rc = (255 * (i4 - 2 * JET_STEPS)) / JET_STEPS;
        gc = 255;
        bc = 0;
      end else begin
        rc = 255;
        gc = (i4 >= 4 * JET_STEPS) ? 0 : (255 * (4 * JET_STEPS - i4)) / JET_STEPS;
        bc = 0;
      end
    end else begin
      hue = ((FX_ONE - norm) * HUE_TOP) >> FRAC_BITS;
      h6 = 6 * hue;
      sector = h6 >> FRAC_BITS;
      frac = h6 & FX_MASK;
      x = sector[0] ? FX_ONE - frac : frac;
      rc = 0;
      gc = 0;
      bc = 0;
      case (sector)
        0: begin
          rc = FX_ONE;
          gc = x;
        end
        1: begin
          rc = x;
          gc = FX_ONE;
        end
        2: begin
          gc = FX_ONE;
          bc = x;
        end
        3: begin
          gc = x;
          bc = FX_ONE;
        end
        4: begin
          rc = x;
          bc = FX_ONE;
        end
        default: begin
          rc = FX_ONE;
          bc = x;
        end
      endcase
      rc = to_channel(rc);
      gc = to_channel(gc);
      bc = to_channel(bc);
    end
    c.red = rc[CHAN_W-1:0];
    c.green = gc[CHAN_W-1:0];
    c.blue = bc[CHAN_W-1:0];
    return c;
  endfunction

  function automatic int unsigned draw_gap(input bit steady);
    return steady ? 0 : $urandom_range(0, 11);
  endfunction

  // Output side: one stall draw per color, held until that color is taken.
  initial begin
    int unsigned stall;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap(sink_steady);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    color_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_colors.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10) begin
          $display("Unexpected color r=%0d g=%0d b=%0d at cycle %0d.",
                   red_o, green_o, blue_o, cycle_count);
        end
      end else begin
        want = pending_colors.pop_front();
        colors_checked <= colors_checked + 1;
        if (want.red !== red_o || want.green !== green_o || want.blue !== blue_o) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) begin
            $display("Color mismatch at cycle %0d: expected r=%0d g=%0d b=%0d,",
                     cycle_count, want.red, want.green, want.blue);
            $display("  got r=%0d g=%0d b=%0d.", red_o, green_o, blue_o);
          end
        end
      end
    end
  end

  task automatic send_value(input logic signed [DATA_W-1:0] sample);
    int unsigned gap;
    gap = draw_gap(src_steady);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i <= sample;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_colors.insert(pending_colors.size(), map_color(sample));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_colors.size() != 0);
  endtask

  task automatic program_span(input cmap_mode_e mode, input logic signed [DATA_W-1:0] low,
                              input logic [DATA_W-1:0] width);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_MODE;
    cfg_wdata_i <= DATA_W'(mode);
    @(posedge clk_i);
    cfg_idx_i <= CFG_LOW;
    cfg_wdata_i <= low;
    @(posedge clk_i);
    cfg_idx_i <= CFG_RANGE;
    cfg_wdata_i <= width;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ramp_mode = mode;
    span_low = low;
    span_width = width;
    settings_used++;
  endtask

  task automatic test_reset_defaults();
    send_value(32'sh0000_0000);
    send_value(32'sh0000_8000);
    send_value(32'sh0001_0000);
    send_value(-32'sd1);
    send_value(32'sh7FFF_FFFF);
    send_value(32'sh8000_0000);
    wait_idle();
  endtask

  task automatic test_jet_segments();
    program_span(MODE_JET, 32'sh0000_0000, RANGE_ONE);
    send_value(32'sh0000_2000);
    send_value(32'sh0000_4000);
    send_value(32'sh0000_6000);
    send_value(32'sh0000_A000);
    send_value(32'sh0000_E000);
    wait_idle();
  endtask

  task automatic test_hue_ramp();
    program_span(MODE_HSV, -32'sh0001_0000, 32'h0002_0000);
    send_value(-32'sh0002_0000);
    send_value(-32'sh0001_0000);
    send_value(32'sh0000_0000);
    send_value(32'sh0000_5555);
    send_value(32'sh0001_0000);
    send_value(32'sh0003_0000);
    wait_idle();
  endtask

  task automatic test_zero_span();
    program_span(MODE_HSV, 32'sh0000_0005, 32'h0000_0000);
    send_value(32'sh0000_0005);
    send_value(32'sh0000_0006);
    send_value(32'sh0001_0004);
    send_value(32'sh0001_0005);
    send_value(32'sh8000_0000);
    wait_idle();
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    longint span;
    longint offset;
    span = (span_width == '0) ? FX_ONE : longint'({32'b0, span_width});
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return span_low;
          default: return DATA_W'(longint'(span_low) + span);
        endcase
      end
      default: begin
        offset = longint'({32'b0, $urandom}) % (span + span / 5 + 2) - span / 10;
        return DATA_W'(longint'(span_low) + offset);
      end
    endcase
  endfunction

  task automatic test_random_spans();
    cmap_mode_e mode;
    logic signed [DATA_W-1:0] low;
    logic [DATA_W-1:0] width;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      mode = (ph % 2 == 0) ? MODE_JET : MODE_HSV;
      low = $urandom;
      case (ph)
        0: begin
          low = 32'sh8000_0000;
          width = 32'hFFFF_FFFF;
        end
        1: begin
          low = 32'sh7FFF_FFFF;
          width = 32'h0000_0000;
        end
        2: width = 32'h0000_0001;
        3: width = 32'hFFFF_FFFF;
        default: begin
          case ($urandom_range(0, 2))
            0: width = $urandom_range(1, 1024);
            1: width = $urandom_range(1024, 32'h00FF_FFFF);
            default: width = $urandom;
          endcase
          if ($urandom_range(0, 2) == 0) begin
            mode = cmap_mode_e'($urandom_range(0, 1));
          end
        end
      endcase
      program_span(mode, low, width);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 37 == 0) begin
          src_steady = ($urandom_range(0, 3) == 0);
          sink_steady = ($urandom_range(0, 3) == 0);
        end
        send_value(pick_value());
      end
      wait_idle();
    end
    src_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_MODE;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    value_i <= '0;
    ramp_mode = MODE_JET;
    span_low = '0;
    span_width = RANGE_ONE;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_jet_segments();
    test_hue_ramp();
    test_zero_span();
    test_random_spans();

    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
    if (pending_colors.size() != 0) begin
      mismatch_count = mismatch_count + pending_colors.size();
    end
    $display("Checked %0d colors over %0d span settings, jet and hue ramps,",
             colors_checked, settings_used);
    $display("including zero, unit and full-width spans; %0d mismatches.", mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
